@@ src/ut2lt_pkg.sv @@
// Package for the UTC to local time converter: zone table, calendar helpers.
// No dependencies.
`default_nettype none
package ut2lt_pkg;
   localparam int ZoneCountDefault = 8;
   localparam int TableSize = 8;

   typedef enum logic [1:0] {
      RULE_NONE  = 2'd0,
      RULE_NORTH = 2'd1,
      RULE_SOUTH = 2'd2
   } rule_type;

   function automatic logic signed [4:0] zone_hours(input logic [2:0] z);
      logic signed [4:0] h;
      unique case (z)
         3'd0: h = 5'sd0;
         3'd1: h = 5'sd1;
         3'd2: h = 5'sd2;
         3'd3: h = -5'sd5;
         3'd4: h = -5'sd4;
         3'd5: h = 5'sd9;
         3'd6: h = 5'sd10;
         default: h = 5'sd12;
      endcase
      return h;
   endfunction

   function automatic rule_type zone_rule(input logic [2:0] z);
      rule_type r;
      unique case (z)
         3'd1, 3'd3: r = RULE_NORTH;
         3'd6, 3'd7: r = RULE_SOUTH;
         default: r = RULE_NONE;
      endcase
      return r;
   endfunction

   // years here lie in 1969..2106, where 2100 is the only century non-leap year
   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != 12'd2100);
   endfunction

   function automatic logic [4:0] days_in(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] d;
      unique case (m)
         4'd2: d = is_leap(y) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   // day of the last Sunday of a month of length len; mod 7 by multiply with 37/256
   function automatic logic [4:0] month_end_sunday(input logic [4:0] len,
                                                   input logic [4:0] d,
                                                   input logic [2:0] w);
      logic [5:0]  s;
      logic [11:0] p;
      s = 6'(w) + 6'(len) - 6'(d);
      p = 12'(s) * 12'd37;
      return len - 5'(s - 6'(p[11:8]) * 6'd7);
   endfunction

   typedef struct packed {
      logic        bad;
      logic [2:0]  zone;
      logic [15:0] days;
      logic [24:0] tshi;
      logic [6:0]  tslo;
   } s1_type;

   typedef struct packed {
      logic        bad;
      logic [2:0]  zone;
      logic [2:0]  wday;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } s2_type;
endpackage
`default_nettype wire

@@ src/ut2lt_date.sv @@
// Day count to civil date and UTC time of day (stages 2 to 4 of the pipeline).
// Depends on ut2lt_pkg.
`default_nettype none
module ut2lt_date import ut2lt_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire s1_type in_data,
   output logic        out_valid,
   output s2_type      out_data
);
   // stage 2: second of day, day count from 1968-03-01, four-year cycle, weekday
   logic        v2_ff;
   logic        bad2_ff;
   logic [2:0]  zone2_ff;
   logic [16:0] sod2_ff;
   logic [2:0]  wday2_ff;
   logic [15:0] e2_ff;
   logic [5:0]  cyc2_ff;
   logic [24:0] hi_rem;
   logic [15:0] e_in;
   logic [32:0] cyc_prod;
   logic [15:0] wx;
   logic [32:0] w_prod;
   logic [15:0] wq;

   // days from 2100-03-01 on skip the missing Feb 29 of 2100
   always_comb begin
      hi_rem = in_data.tshi - 25'(in_data.days) * 25'd675;
      e_in = in_data.days + 16'd671 + ((in_data.days >= 16'd47541) ? 16'd1 : 16'd0);
      cyc_prod = 33'(e_in) * 33'd91868;
      wx = in_data.days + 16'd4;
      w_prod = 33'(wx) * 33'd74899;
      wq = 16'(w_prod[32:19]);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= in_valid;
      bad2_ff <= in_data.bad;
      zone2_ff <= in_data.zone;
      sod2_ff <= {hi_rem[9:0], in_data.tslo};
      wday2_ff <= 3'(wx - wq * 16'd7);
      e2_ff <= e_in;
      cyc2_ff <= cyc_prod[32:27];
   end

   // stage 3: year within the cycle, day of the March-based year, hour
   logic        v3_ff;
   logic        bad3_ff;
   logic [2:0]  zone3_ff;
   logic [2:0]  wday3_ff;
   logic [11:0] ym3_ff;
   logic [8:0]  doy3_ff;
   logic [4:0]  hr3_ff;
   logic [11:0] rem3_ff;
   logic [10:0] yr_rem;
   logic [1:0]  yc;
   logic [31:0] h_prod;
   logic [4:0]  h_in;

   always_comb begin
      yr_rem = 11'(e2_ff - 16'(cyc2_ff) * 16'd1461);
      priority if (yr_rem >= 11'd1095) yc = 2'd3;
      else if (yr_rem >= 11'd730) yc = 2'd2;
      else if (yr_rem >= 11'd365) yc = 2'd1;
      else yc = 2'd0;
      h_prod = 32'(sod2_ff) * 32'd37283;
      h_in = h_prod[31:27];
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      bad3_ff <= bad2_ff;
      zone3_ff <= zone2_ff;
      wday3_ff <= wday2_ff;
      ym3_ff <= 12'd1968 + 12'({cyc2_ff, 2'b00}) + 12'(yc);
      doy3_ff <= 9'(yr_rem - 11'(yc) * 11'd365);
      hr3_ff <= h_in;
      rem3_ff <= 12'(sod2_ff - 17'(h_in) * 17'd3600);
   end

   // stage 4: month and day, minute and second
   logic [3:0]  mp;
   logic [8:0]  mstart;
   logic [3:0]  mo;
   logic [23:0] m_prod;
   logic [5:0]  mi;

   always_comb begin
      priority if (doy3_ff >= 9'd337) begin
         mp = 4'd11; mstart = 9'd337;
      end else if (doy3_ff >= 9'd306) begin
         mp = 4'd10; mstart = 9'd306;
      end else if (doy3_ff >= 9'd275) begin
         mp = 4'd9; mstart = 9'd275;
      end else if (doy3_ff >= 9'd245) begin
         mp = 4'd8; mstart = 9'd245;
      end else if (doy3_ff >= 9'd214) begin
         mp = 4'd7; mstart = 9'd214;
      end else if (doy3_ff >= 9'd184) begin
         mp = 4'd6; mstart = 9'd184;
      end else if (doy3_ff >= 9'd153) begin
         mp = 4'd5; mstart = 9'd153;
      end else if (doy3_ff >= 9'd122) begin
         mp = 4'd4; mstart = 9'd122;
      end else if (doy3_ff >= 9'd92) begin
         mp = 4'd3; mstart = 9'd92;
      end else if (doy3_ff >= 9'd61) begin
         mp = 4'd2; mstart = 9'd61;
      end else if (doy3_ff >= 9'd31) begin
         mp = 4'd1; mstart = 9'd31;
      end else begin
         mp = 4'd0; mstart = 9'd0;
      end
      mo = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      m_prod = 24'(rem3_ff) * 24'd4370;
      mi = m_prod[23:18];
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else out_valid <= v3_ff;
      out_data.bad <= bad3_ff;
      out_data.zone <= zone3_ff;
      out_data.wday <= wday3_ff;
      out_data.year <= ym3_ff + ((mo <= 4'd2) ? 12'd1 : 12'd0);
      out_data.month <= mo;
      out_data.day <= 5'(doy3_ff - mstart + 9'd1);
      out_data.hour <= hr3_ff;
      out_data.minute <= mi;
      out_data.second <= 6'(rem3_ff - 12'(mi) * 12'd60);
   end
endmodule
`default_nettype wire

@@ src/ut2lt_local.sv @@
// DST decision, offset and date rollover (stages 5 and 6).
// Depends on ut2lt_pkg.
`default_nettype none
module ut2lt_local import ut2lt_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire s2_type in_data,
   output logic        out_valid,
   output logic        status,
   output logic [11:0] year,
   output logic [3:0]  month,
   output logic [4:0]  day,
   output logic [4:0]  hour,
   output logic [5:0]  minute,
   output logic [5:0]  second,
   output logic [2:0]  weekday,
   output logic        dst,
   output logic signed [4:0] off_hours
);
   logic dst_c;
   logic signed [4:0] off_c;
   logic signed [6:0] hsum_in;
   rule_type rl;
   always_comb begin
      rl = zone_rule(in_data.zone);
      dst_c = 1'b0;
      unique case (rl)
         RULE_NORTH: begin
            if (in_data.month > 4'd3 && in_data.month < 4'd10) dst_c = 1'b1;
            else if (in_data.month == 4'd3)
               dst_c = in_data.day >= month_end_sunday(5'd31, in_data.day, in_data.wday);
            else if (in_data.month == 4'd10)
               dst_c = in_data.day < month_end_sunday(5'd31, in_data.day, in_data.wday);
         end
         RULE_SOUTH: begin
            if (in_data.month > 4'd10 || in_data.month < 4'd4) dst_c = 1'b1;
            else if (in_data.month == 4'd10)
               dst_c = in_data.day >= month_end_sunday(5'd31, in_data.day, in_data.wday);
            else if (in_data.month == 4'd4)
               dst_c = in_data.day < month_end_sunday(5'd30, in_data.day, in_data.wday);
         end
         default: dst_c = 1'b0;
      endcase
      off_c = zone_hours(in_data.zone) + (dst_c ? 5'sd1 : 5'sd0);
      hsum_in = $signed({2'b00, in_data.hour}) + $signed({{2{off_c[4]}}, off_c});
   end

   logic        v5_ff;
   s2_type      d5_ff;
   logic        dst5_ff;
   logic signed [4:0] off5_ff;
   logic signed [6:0] hsum5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= in_valid;
      d5_ff <= in_data;
      dst5_ff <= dst_c;
      off5_ff <= off_c;
      hsum5_ff <= hsum_in;
   end

   // offsets are whole hours: minute and second pass through unchanged
   logic [4:0]  h;
   logic [11:0] y;
   logic [3:0]  m;
   logic [4:0]  d;
   logic [2:0]  w;
   always_comb begin
      y = d5_ff.year;
      m = d5_ff.month;
      d = d5_ff.day;
      w = d5_ff.wday;
      h = 5'(hsum5_ff);
      if (hsum5_ff < 7'sd0) begin
         h = 5'(hsum5_ff + 7'sd24);
         w = (w == 3'd0) ? 3'd6 : w - 3'd1;
         if (d > 5'd1) begin
            d = d - 5'd1;
         end else begin
            if (m > 4'd1) begin
               m = m - 4'd1;
            end else begin
               m = 4'd12;
               y = y - 12'd1;
            end
            d = days_in(y, m);
         end
      end else if (hsum5_ff >= 7'sd24) begin
         h = 5'(hsum5_ff - 7'sd24);
         w = (w == 3'd6) ? 3'd0 : w + 3'd1;
         if (d >= days_in(y, m)) begin
            d = 5'd1;
            if (m >= 4'd12) begin
               m = 4'd1;
               y = y + 12'd1;
            end else begin
               m = m + 4'd1;
            end
         end else begin
            d = d + 5'd1;
         end
      end
   end

   logic bad;
   assign bad = d5_ff.bad;
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else out_valid <= v5_ff;
      status <= bad;
      year <= bad ? '0 : y;
      month <= bad ? '0 : m;
      day <= bad ? '0 : d;
      hour <= bad ? '0 : h;
      minute <= bad ? '0 : d5_ff.minute;
      second <= bad ? '0 : d5_ff.second;
      weekday <= bad ? '0 : w;
      dst <= bad ? 1'b0 : dst5_ff;
      off_hours <= bad ? '0 : off5_ff;
   end
endmodule
`default_nettype wire

@@ src/utc_to_local_time_with_dst.sv @@
// Top level of the UTC to local time converter.
// Depends on ut2lt_pkg, ut2lt_date, ut2lt_local.
//
// Usage:
//   Drive req_timestamp_utc and req_zone with start high; the request is
//   taken at that edge (busy is always low, one request per cycle).
//   Each result passes through stages 1 to 6 and appears on the rsp_ ports for one cycle
//   with rsp_valid high. Throughput is one request per clock.
//   Stage 1 finds the day count, stage 2 the second of day, four-year cycle
//   and weekday, stages 3 and 4 the civil date and UTC time of day, stage 5
//   decides DST and adds the offset, stage 6 rolls the date.
//   Zones at or beyond ZONE_COUNT or TableSize give rsp_status 1, other fields zero.
//   Synchronous reset empties the pipeline; requests in flight are lost.
//   The receiver cannot stall; results must be taken when strobed.
`default_nettype none
module utc_to_local_time_with_dst import ut2lt_pkg::*; #(
   parameter int ZONE_COUNT = ZoneCountDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_timestamp_utc,
   input  wire logic [3:0]  req_zone,
   output logic             rsp_valid,
   output logic             rsp_status,
   output logic [11:0]      rsp_local_year,
   output logic [3:0]       rsp_local_month,
   output logic [4:0]       rsp_local_day,
   output logic [4:0]       rsp_local_hour,
   output logic [5:0]       rsp_local_minute,
   output logic [5:0]       rsp_local_second,
   output logic [2:0]       rsp_local_weekday,
   output logic             rsp_dst_active,
   output logic signed [4:0] rsp_offset_hours,
   output logic [5:0]       rsp_offset_minutes
);
   logic        v1_ff;
   s1_type      s1_ff;
   logic        v4;
   s2_type      s4;
   logic [50:0] days_prod;

   assign busy = 1'b0;
   assign rsp_offset_minutes = '0;

   // days = (ts >> 7) / 675 by reciprocal multiply
   assign days_prod = 51'(req_timestamp_utc[31:7]) * 51'd50903317;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      s1_ff.bad <= (5'(req_zone) >= 5'(ZONE_COUNT)) || (5'(req_zone) >= 5'(TableSize));
      s1_ff.zone <= req_zone[2:0];
      s1_ff.days <= days_prod[50:35];
      s1_ff.tshi <= req_timestamp_utc[31:7];
      s1_ff.tslo <= req_timestamp_utc[6:0];
   end

   ut2lt_date u_date (
      .clock(clock), .reset(reset), .in_valid(v1_ff), .in_data(s1_ff),
      .out_valid(v4), .out_data(s4)
   );

   ut2lt_local u_local (
      .clock(clock), .reset(reset), .in_valid(v4), .in_data(s4),
      .out_valid(rsp_valid), .status(rsp_status), .year(rsp_local_year),
      .month(rsp_local_month), .day(rsp_local_day), .hour(rsp_local_hour),
      .minute(rsp_local_minute), .second(rsp_local_second),
      .weekday(rsp_local_weekday), .dst(rsp_dst_active), .off_hours(rsp_offset_hours)
   );
endmodule
`default_nettype wire
